### hdl/fupd_pkg.sv
// Package for the file URL decoder: phase codes, character constants and helpers.
package fupd_pkg;

    localparam int UnitW     = 16;
    localparam int PrefixLen = 7;
    localparam int PosW      = $clog2(PrefixLen);

    localparam logic [UnitW-1:0] ChSlash     = 16'h002F;
    localparam logic [UnitW-1:0] ChBackslash = 16'h005C;
    localparam logic [UnitW-1:0] ChPercent   = 16'h0025;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_SLASH  = 3'd1,
        PH_BODY   = 3'd2,
        PH_ESC_HI = 3'd3,
        PH_ESC_LO = 3'd4,
        PH_FAIL   = 3'd5
    } t_phase;

    typedef struct packed {
        logic             emit;
        logic [UnitW-1:0] path_unit;
        logic             has_char;
        logic             done_res;
        logic             accepted;
    } t_result;

    // Expected unit of "file://" at a given position.
    function automatic logic [UnitW-1:0] prefix_unit(input logic [PosW-1:0] pos);
        logic [UnitW-1:0] u;
        begin
            unique case (pos)
                3'd0:    u = 16'h0066;
                3'd1:    u = 16'h0069;
                3'd2:    u = 16'h006C;
                3'd3:    u = 16'h0065;
                3'd4:    u = 16'h003A;
                3'd5:    u = 16'h002F;
                3'd6:    u = 16'h002F;
                default: u = '0;
            endcase
            return u;
        end
    endfunction

    // Bit 4 set means the unit is not an ASCII hex digit; bits 3:0 hold the value.
    function automatic logic [4:0] hex_value(input logic [UnitW-1:0] u);
        logic [4:0] d;
        begin
            if (u >= 16'h0030 && u <= 16'h0039) begin
                d = {1'b0, 4'(u - 16'h0030)};
            end else if (u >= 16'h0061 && u <= 16'h0066) begin
                d = {1'b0, 4'(u - 16'h0061 + 16'd10)};
            end else if (u >= 16'h0041 && u <= 16'h0046) begin
                d = {1'b0, 4'(u - 16'h0041 + 16'd10)};
            end else begin
                d = 5'b10000;
            end
            return d;
        end
    endfunction

endpackage

### hdl/fupd_core.sv
// Decoding state machine: prefix check, optional slash, body and percent escapes.
module fupd_core
    import fupd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [UnitW-1:0] i_code_unit,
    input  logic             i_is_end,
    output t_result          o_res
);

    t_phase           r_phase, n_phase;
    logic [PosW-1:0]  r_pos, n_pos;
    logic [3:0]       r_high, n_high;
    logic [4:0]       hex_d;

    assign hex_d = hex_value(i_code_unit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_pos   <= '0;
            r_high  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_high  <= n_high;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_high  = r_high;
        o_res   = '0;
        if (i_is_end) begin
            o_res.emit     = 1'b1;
            o_res.done_res = 1'b1;
            o_res.accepted = (r_phase == PH_SLASH) || (r_phase == PH_BODY);
            n_phase        = PH_PREFIX;
            n_pos          = '0;
            n_high         = '0;
        end else begin
            unique case (r_phase)
                PH_PREFIX: begin
                    if (i_code_unit == prefix_unit(r_pos)) begin
                        n_pos = PosW'(r_pos + 1'b1);
                        if (r_pos == PosW'(PrefixLen - 1)) begin
                            n_phase = PH_SLASH;
                        end
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_SLASH, PH_BODY: begin
                    n_phase = PH_BODY;
                    if (i_code_unit == ChSlash) begin
                        // A slash directly after the prefix is dropped silently.
                        if (r_phase == PH_BODY) begin
                            o_res.emit      = 1'b1;
                            o_res.has_char  = 1'b1;
                            o_res.path_unit = ChBackslash;
                        end
                    end else if (i_code_unit == ChPercent) begin
                        n_phase = PH_ESC_HI;
                    end else begin
                        o_res.emit      = 1'b1;
                        o_res.has_char  = 1'b1;
                        o_res.path_unit = i_code_unit;
                    end
                end
                PH_ESC_HI: begin
                    if (hex_d[4]) begin
                        n_phase = PH_FAIL;
                    end else begin
                        n_high  = hex_d[3:0];
                        n_phase = PH_ESC_LO;
                    end
                end
                PH_ESC_LO: begin
                    if (hex_d[4]) begin
                        n_phase = PH_FAIL;
                    end else begin
                        n_phase         = PH_BODY;
                        o_res.emit      = 1'b1;
                        o_res.has_char  = 1'b1;
                        o_res.path_unit = UnitW'({r_high, hex_d[3:0]});
                    end
                end
                default: begin
                    n_phase = PH_FAIL;
                end
            endcase
        end
    end

    // A terminator always returns the decoder to its starting state.
    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_is_end |=> r_phase == PH_PREFIX && r_pos == '0 && r_high == '0)
        else $error("terminator did not restart the decoder");

    // Apart from a terminator, the prefix counter only moves while the prefix is being matched.
    a_pos_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_is_end && r_phase != PH_PREFIX |=> $stable(r_pos))
        else $error("prefix position moved outside prefix matching");

endmodule

### hdl/file_url_to_path_decoder_top.sv
// Top level of the file URL to path decoder with its input and result registers.
//
// The block takes a file URL one 16-bit code unit per request and a terminator request
// (tlast high) at the end. It checks the case-sensitive prefix "file://", drops one
// further slash, turns every other '/' into a backslash and replaces "%hh" by the byte
// value of the two hex digits; each decoded unit leaves as one result request. The
// terminator yields a final request with tlast high whose accepted flag tells whether
// the URL was well formed; after a malformed prefix, a bad hex digit or a terminator
// inside an escape, units are swallowed and the final flag is low. One request is taken
// every clock cycle unless the result register stalls; a code unit passes through the
// input register and the state machine into the result register, which offers its
// result. Prefix units, the dropped slash, '%' and the first hex digit give no result.
module file_url_to_path_decoder_top
    import fupd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tlast,   // is_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] path_unit
    output logic        m_axis_tlast,   // done_res
    output logic [1:0]  m_axis_tuser    // [0] has_char, [1] accepted
);

    // Input register stage.
    logic             r_in_valid;
    logic [UnitW-1:0] r_in_unit;
    logic             r_in_end;

    // Result register stage.
    logic             r_out_valid;
    logic [UnitW-1:0] r_out_unit;
    logic             r_out_has_char;
    logic             r_out_done;
    logic             r_out_accepted;

    logic    out_free;
    logic    advance;
    t_result res;

    // The result register can take a new value when it is empty or being drained,
    // and the input stage moves on whenever that is so.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_unit <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    fupd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_code_unit (r_in_unit),
        .i_is_end    (r_in_end),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_unit     <= res.path_unit;
            r_out_has_char <= res.has_char;
            r_out_done     <= res.done_res;
            r_out_accepted <= res.accepted;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_unit;
    assign m_axis_tlast  = r_out_done;
    assign m_axis_tuser  = {r_out_accepted, r_out_has_char};

    // A final request never carries a character, and a character never a verdict.
    a_done_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast != m_axis_tuser[0]))
        else $error("result is neither a character nor a final status");

    // The accepted flag only appears on the final request.
    a_accept_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("accepted flag outside a final request");

    // A terminator that moves on always leaves a final request in the result register.
    a_end_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_end |=> r_out_valid && r_out_done)
        else $error("terminator produced no final request");

    // The input stage never holds an item that is dropped unprocessed.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_unit) && $stable(r_in_end))
        else $error("pending input item overwritten");

endmodule
